[sv/skft_pkg.sv]
// Package: shared types and codes for the seen-kernel FIFO table.
package skft_pkg;

  typedef enum logic [1:0] {
    CMD_CHECK  = 2'd0,
    CMD_CHKREC = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_RECORD = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_NOT_SEEN   = 2'd0,
    ST_SEEN_SAME  = 2'd1,
    ST_SEEN_OTHER = 2'd2,
    ST_FULL       = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] key_txid_w0;
    logic [63:0] key_txid_w1;
    logic [63:0] key_txid_w2;
    logic [63:0] key_txid_w3;
    logic [31:0] key_out_index;
    logic [63:0] block_hash_w0;
    logic [63:0] block_hash_w1;
    logic [63:0] block_hash_w2;
    logic [63:0] block_hash_w3;
  } in_beat_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  status;
    logic [10:0] held_entries;
  } out_beat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_WAIT,
    S_CMP,
    S_DECIDE,
    S_OUT
  } state_t;

  localparam int KeyW  = 288;
  localparam int HashW = 256;

endpackage

[sv/skft_ram.sv]
// Generic single-port-write, registered-read RAM.
module skft_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[sv/skft_cmp.sv]
// Shared compare unit: registered key and hash equality of one stored entry.
module skft_cmp (
  input  logic                      clk,
  input  logic [skft_pkg::KeyW-1:0]  key_a,
  input  logic [skft_pkg::KeyW-1:0]  key_b,
  input  logic [skft_pkg::HashW-1:0] hash_a,
  input  logic [skft_pkg::HashW-1:0] hash_b,
  output logic                      key_eq_r,
  output logic                      hash_eq_r
);
  import skft_pkg::*;

  always_ff @(posedge clk) begin
    key_eq_r  <= (key_a == key_b);
    hash_eq_r <= (hash_a == hash_b);
  end
endmodule

[sv/seen_kernel_fifo_table_core.sv]
// Top level: seen-kernel FIFO table with a sequential scan over a ring RAM.
// Each held entry scanned passes through S_READ, S_WAIT and S_CMP; then come S_DECIDE and S_OUT.
// Throughput: one beat at a time; in_ready is low until the result is taken.
// The scan reads one slot per iteration from the ring RAM through one comparator.
// Reset (rst_n low, synchronous) empties the table; RAM contents stay undefined.
module seen_kernel_fifo_table_core #(
  parameter int LIMIT = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  skft_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output skft_pkg::out_beat_t out_data
);
  import skft_pkg::*;

  localparam int Slots = LIMIT + 1;
  localparam int AW    = $clog2(Slots + 1);
  localparam int RW    = $clog2(Slots);

  state_t        state_r, state_nxt;
  in_beat_t      item_r;
  logic [AW-1:0] count_r, count_nxt;
  logic [RW-1:0] oldest_r, oldest_nxt;
  logic [AW-1:0] scan_r, scan_nxt;
  logic [RW-1:0] slot_r, slot_nxt;
  logic          found_r, found_nxt;
  logic          heq_r, heq_nxt;
  logic [RW-1:0] fslot_r, fslot_nxt;
  out_beat_t     res_r, res_nxt;

  logic                  key_we, hash_we;
  logic [RW-1:0]         waddr;
  logic [KeyW-1:0]       key_rd, key_in;
  logic [HashW-1:0]      hash_rd, hash_in;
  logic                  key_eq, hash_eq;
  logic [RW-1:0]         app_slot;
  logic [RW:0]           app_sum;

  function automatic logic [KeyW-1:0] in_data_key(in_beat_t b);
    return {b.key_out_index, b.key_txid_w3, b.key_txid_w2, b.key_txid_w1, b.key_txid_w0};
  endfunction

  assign key_in  = {in_data_key(item_r)};
  assign hash_in = {item_r.block_hash_w3, item_r.block_hash_w2,
                    item_r.block_hash_w1, item_r.block_hash_w0};

  skft_ram #(.Width(KeyW), .Depth(Slots)) u_key_ram (
    .clk, .we(key_we), .waddr, .wdata(key_in), .raddr(slot_r), .rdata(key_rd)
  );

  skft_ram #(.Width(HashW), .Depth(Slots)) u_hash_ram (
    .clk, .we(hash_we), .waddr, .wdata(hash_in), .raddr(slot_r), .rdata(hash_rd)
  );

  skft_cmp u_cmp (
    .clk, .key_a(key_rd), .key_b(key_in), .hash_a(hash_rd), .hash_b(hash_in),
    .key_eq_r(key_eq), .hash_eq_r(hash_eq)
  );

  // append slot = (oldest + count) mod Slots; sum stays below 2*Slots
  always_comb begin
    app_sum = {1'b0, oldest_r} + (RW+1)'(count_r);
    if (app_sum >= (RW+1)'(Slots)) begin
      app_sum = app_sum - (RW+1)'(Slots);
    end
    app_slot = app_sum[RW-1:0];
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      oldest_r <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      oldest_r <= oldest_nxt;
    end
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    scan_r  <= scan_nxt;
    slot_r  <= slot_nxt;
    found_r <= found_nxt;
    heq_r   <= heq_nxt;
    fslot_r <= fslot_nxt;
    res_r   <= res_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    oldest_nxt = oldest_r;
    scan_nxt   = scan_r;
    slot_nxt   = slot_r;
    found_nxt  = found_r;
    heq_nxt    = heq_r;
    fslot_nxt  = fslot_r;
    res_nxt    = res_r;
    key_we     = 1'b0;
    hash_we    = 1'b0;
    waddr      = app_slot;
    case (state_r)
      S_IDLE: begin
        scan_nxt  = '0;
        slot_nxt  = oldest_r;
        found_nxt = 1'b0;
        heq_nxt   = 1'b0;
        if (in_valid) begin
          state_nxt = (count_r == '0) ? S_DECIDE : S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        state_nxt = S_READ;
        if (key_eq) begin
          found_nxt = 1'b1;
          heq_nxt   = hash_eq;
          fslot_nxt = slot_r;
          state_nxt = S_DECIDE;
        end else if (scan_r + AW'(1) >= count_r) begin
          state_nxt = S_DECIDE;
        end else begin
          scan_nxt = scan_r + AW'(1);
          slot_nxt = (slot_r == RW'(Slots - 1)) ? '0 : slot_r + RW'(1);
        end
      end
      S_DECIDE: begin
        state_nxt = S_OUT;
        res_nxt.accepted = 1'b1;
        res_nxt.status   = ST_NOT_SEEN;
        case (cmd_t'(item_r.cmd))
          CMD_QUERY: begin
            if (found_r) begin
              res_nxt.accepted = 1'b0;
              res_nxt.status   = ST_SEEN_SAME;
            end
          end
          CMD_RECORD: begin
            if (found_r) begin
              res_nxt.status = heq_r ? ST_SEEN_SAME : ST_SEEN_OTHER;
              hash_we = 1'b1;
              waddr   = fslot_r;
            end else if (count_r >= AW'(Slots)) begin
              res_nxt.accepted = 1'b0;
              res_nxt.status   = ST_FULL;
            end else begin
              key_we    = 1'b1;
              hash_we   = 1'b1;
              count_nxt = count_r + AW'(1);
            end
          end
          default: begin
            if (found_r) begin
              if (heq_r) begin
                res_nxt.status = ST_SEEN_SAME;
              end else begin
                res_nxt.accepted = 1'b0;
                res_nxt.status   = ST_SEEN_OTHER;
              end
            end else if (item_r.cmd == CMD_CHKREC) begin
              key_we  = 1'b1;
              hash_we = 1'b1;
              if (count_r > AW'(LIMIT)) begin
                // drop oldest; its slot is the append slot
                waddr      = oldest_r;
                oldest_nxt = (oldest_r == RW'(Slots - 1)) ? '0 : oldest_r + RW'(1);
              end else begin
                count_nxt = count_r + AW'(1);
              end
            end
          end
        endcase
        res_nxt.held_entries = 11'(count_nxt);
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= AW'(Slots)) else $error("entry count above ring size");
  a_oldest_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oldest_r <= RW'(Slots - 1)) else $error("oldest slot out of range");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_DECIDE) |=> $stable(count_r) && $stable(oldest_r))
    else $error("table changed outside decide");
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result held");
endmodule
